[rtl/rti_pkg.sv]
// Shared types, constants and wide-product helpers for the ray/triangle test.
`default_nettype none
package rti_pkg;

  // Field and internal widths
  localparam int CW     = 32;          // coordinate width
  localparam int FRAC   = 16;          // fraction bits
  localparam int EW     = CW + 1;      // edge and offset width
  localparam int XW     = 2 * EW;      // one cross-product term
  localparam int PW     = XW + 1;      // cross-product component
  localparam int DW     = 104;         // determinant and numerators
  localparam int QW     = 136;         // division remainder
  localparam int DIST_W = 31;          // distance width
  localparam int DIV_STAGES = DIST_W;  // one quotient bit per stage

  // Largest |det| that still counts as parallel: floor(2^48 / 1000)
  localparam logic [DW-1:0] DET_MIN = DW'(64'd281474976710);

  // Register indexes
  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;

  typedef logic signed [EW-1:0] ext_t;
  typedef logic signed [XW-1:0] prod_t;
  typedef logic signed [PW-1:0] vec_t;
  typedef logic signed [DW-1:0] wide_t;

  // Partial products of a 33-bit by 67-bit multiply
  typedef struct packed {
    logic signed [EW+2:0] hi;
    logic signed [XW-1:0] mid;
    logic signed [XW-1:0] lo;
  } part_t;

  // Sign-extend a coordinate
  function automatic ext_t sx(input logic [CW-1:0] c);
    return ext_t'($signed({c[CW-1], c}));
  endfunction

  // Split b into two unsigned 32-bit chunks and a signed top chunk
  function automatic part_t mul_split(input ext_t a, input vec_t b);
    part_t r;
    logic signed [EW-1:0] blo;
    logic signed [EW-1:0] bmid;
    logic signed [2:0]    bhi;
    blo  = $signed({1'b0, b[31:0]});
    bmid = $signed({1'b0, b[63:32]});
    bhi  = $signed(b[PW-1:64]);
    r.lo  = a * blo;
    r.mid = a * bmid;
    r.hi  = a * bhi;
    return r;
  endfunction

  // Recombine the partial products
  function automatic wide_t part_sum(input part_t p);
    wide_t h;
    wide_t m;
    wide_t l;
    h = DW'(p.hi);
    m = DW'(p.mid);
    l = DW'(p.lo);
    return (h <<< 64) + (m <<< 32) + l;
  endfunction

endpackage
`default_nettype wire

[rtl/ray_triangle_intersect.sv]
// Ray/triangle intersection test, top level.
//
// One triangle word is taken per clock and one result word leaves per clock
// while the output is not stalled. The path is eight arithmetic stages
// (edges, cross terms, cross sums, dot partial products, product sums, dot
// sums, sign fix, range tests), then 31 restoring divider stages that each
// give one distance bit, then the output register. Any stall on the output
// holds the whole pipeline in place. The user must write ray origin and
// direction through the configuration port only while no triangle is in
// flight; the block itself does not enforce this.
`default_nettype none
module ray_triangle_intersect import rti_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z, 32 bits each
  input  wire logic [287:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // hit [0], distance [31:1]
  output logic [31:0]        m_tdata
);

  localparam int NV = 8 + DIV_STAGES;

  logic [CW-1:0] org [3];
  logic [CW-1:0] dir [3];
  logic [NV-1:0] vld;
  logic          en;

  ext_t  e1_1 [3], e2_1 [3], s_1 [3];
  prod_t pp_2 [6], qq_2 [6];
  ext_t  e1_2 [3], e2_2 [3], s_2 [3];
  vec_t  p_3 [3], q_3 [3];
  ext_t  e1_3 [3], e2_3 [3], s_3 [3];
  part_t det_4 [3], nu_4 [3], nv_4 [3], nt_4 [3];
  wide_t det_5 [3], nu_5 [3], nv_5 [3], nt_5 [3];
  wide_t det_6, nu_6, nv_6, nt_6;
  wide_t det_7, nu_7, nv_7, nt_7;
  logic  hit_8, pos_8, sat_8;
  logic [QW-1:0] n_8, d_8;

  logic [QW-1:0]     dn   [DIV_STAGES];
  logic [QW-1:0]     dd   [DIV_STAGES];
  logic [DIST_W-1:0] dq   [DIV_STAGES];
  logic              dhit [DIV_STAGES];
  logic              dpos [DIV_STAGES];
  logic              dsat [DIV_STAGES];
  logic [QW-1:0]     dn_next [DIV_STAGES];
  logic [DIST_W-1:0] dq_next [DIV_STAGES];

  logic [DIST_W-1:0] dist_next;

  // Advance every stage when the output register is free
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_DIR_X: dir[0] <= cfg_data;
        REG_DIR_Y: dir[1] <= cfg_data;
        REG_DIR_Z: dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NV-2:0], s_tvalid};
      m_tvalid <= vld[NV-1];
    end
  end

  // Stages 1 to 3: edges, cross terms, cross sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1[i] <= sx(s_tdata[32*(3+i) +: 32]) - sx(s_tdata[32*i +: 32]);
        e2_1[i] <= sx(s_tdata[32*(6+i) +: 32]) - sx(s_tdata[32*i +: 32]);
        s_1[i]  <= sx(org[i]) - sx(s_tdata[32*i +: 32]);
      end
      pp_2[0] <= sx(dir[1]) * e2_1[2];
      pp_2[1] <= sx(dir[2]) * e2_1[1];
      pp_2[2] <= sx(dir[2]) * e2_1[0];
      pp_2[3] <= sx(dir[0]) * e2_1[2];
      pp_2[4] <= sx(dir[0]) * e2_1[1];
      pp_2[5] <= sx(dir[1]) * e2_1[0];
      qq_2[0] <= s_1[1] * e1_1[2];
      qq_2[1] <= s_1[2] * e1_1[1];
      qq_2[2] <= s_1[2] * e1_1[0];
      qq_2[3] <= s_1[0] * e1_1[2];
      qq_2[4] <= s_1[0] * e1_1[1];
      qq_2[5] <= s_1[1] * e1_1[0];
      for (int i = 0; i < 3; i++) begin
        e1_2[i] <= e1_1[i];
        e2_2[i] <= e2_1[i];
        s_2[i]  <= s_1[i];
        p_3[i]  <= PW'(pp_2[2*i]) - PW'(pp_2[2*i+1]);
        q_3[i]  <= PW'(qq_2[2*i]) - PW'(qq_2[2*i+1]);
        e1_3[i] <= e1_2[i];
        e2_3[i] <= e2_2[i];
        s_3[i]  <= s_2[i];
      end
    end
  end

  // Stages 4 to 7: dot products as partial products, sums, sign fix
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        det_4[i] <= mul_split(e1_3[i], p_3[i]);
        nu_4[i]  <= mul_split(s_3[i], p_3[i]);
        nv_4[i]  <= mul_split(sx(dir[i]), q_3[i]);
        nt_4[i]  <= mul_split(e2_3[i], q_3[i]);
        det_5[i] <= part_sum(det_4[i]);
        nu_5[i]  <= part_sum(nu_4[i]);
        nv_5[i]  <= part_sum(nv_4[i]);
        nt_5[i]  <= part_sum(nt_4[i]);
      end
      det_6 <= det_5[0] + det_5[1] + det_5[2];
      nu_6  <= nu_5[0] + nu_5[1] + nu_5[2];
      nv_6  <= nv_5[0] + nv_5[1] + nv_5[2];
      nt_6  <= nt_5[0] + nt_5[1] + nt_5[2];
      if (det_6[DW-1]) begin
        det_7 <= -det_6;
        nu_7  <= -nu_6;
        nv_7  <= -nv_6;
        nt_7  <= -nt_6;
      end else begin
        det_7 <= det_6;
        nu_7  <= nu_6;
        nv_7  <= nv_6;
        nt_7  <= nt_6;
      end
    end
  end

  // Stage 8: range tests and divider set-up
  always_ff @(posedge clk) begin
    if (en) begin
      hit_8 <= ($unsigned(det_7) > DET_MIN) && !nu_7[DW-1] && (nu_7 <= det_7)
               && !nv_7[DW-1] && ((nu_7 + nv_7) <= det_7);
      pos_8 <= !nt_7[DW-1] && (nt_7 != '0);
      sat_8 <= QW'($unsigned(nt_7)) >= (QW'($unsigned(det_7)) << 15);
      n_8   <= nt_7[DW-1] ? '0 : (QW'($unsigned(nt_7)) << FRAC);
      d_8   <= QW'($unsigned(det_7));
    end
  end

  // Divider: one restoring step per stage, most significant bit first
  always_comb begin
    logic [QW-1:0]     n_in;
    logic [QW-1:0]     d_in;
    logic [DIST_W-1:0] q_in;
    logic [QW-1:0]     dsh;
    for (int k = 0; k < DIV_STAGES; k++) begin
      n_in = (k == 0) ? n_8 : dn[(k == 0) ? 0 : k-1];
      d_in = (k == 0) ? d_8 : dd[(k == 0) ? 0 : k-1];
      q_in = (k == 0) ? '0  : dq[(k == 0) ? 0 : k-1];
      dsh  = d_in << (DIV_STAGES - 1 - k);
      if (n_in >= dsh) begin
        dn_next[k] = n_in - dsh;
        dq_next[k] = q_in | (DIST_W'(1) << (DIV_STAGES - 1 - k));
      end else begin
        dn_next[k] = n_in;
        dq_next[k] = q_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dn[k] <= dn_next[k];
        dq[k] <= dq_next[k];
        if (k == 0) begin
          dd[k]   <= d_8;
          dhit[k] <= hit_8;
          dpos[k] <= pos_8;
          dsat[k] <= sat_8;
        end else begin
          dd[k]   <= dd[k-1];
          dhit[k] <= dhit[k-1];
          dpos[k] <= dpos[k-1];
          dsat[k] <= dsat[k-1];
        end
      end
    end
  end

  // Pick the distance: zero on miss or behind the origin, clamp on overflow
  always_comb begin
    if (!dhit[DIV_STAGES-1] || !dpos[DIV_STAGES-1]) begin
      dist_next = '0;
    end else if (dsat[DIV_STAGES-1]) begin
      dist_next = '1;
    end else begin
      dist_next = dq[DIV_STAGES-1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {dist_next, dhit[DIV_STAGES-1]};
    end
  end

  // A miss always carries zero distance
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[31:1] == '0))
    else $error("miss word with non-zero distance");

  // A stalled pipeline keeps its first stage
  assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !en) |=> vld[0])
    else $error("word lost in stalled pipeline");

  // Nothing valid straight after reset
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && (vld == '0)))
    else $error("valid bits set after reset");

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the ray/triangle intersection block.
`default_nettype none
module tb import rti_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] exact_t;

  typedef struct {
    logic [287:0] tri_word;
    bit           typed;
    bit           far;
    logic [31:0]  want;
  } row_t;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] FIVE = 32'h0005_0000;
  localparam logic [31:0] QTR  = 32'h0000_4000;
  localparam logic [31:0] DIST_SAT = {31'h7FFF_FFFF, 1'b1};
  localparam logic [31:0] MISS_WORD = 32'd0;
  localparam int LIMIT_CYCLES = 600000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;

  logic signed [31:0] ray_reg [6];
  logic [31:0] result_q [$];
  int  errors;
  int  cycles;
  bit  calm;
  bit  hold_req;

  ray_triangle_intersect u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact hit test and distance for one triangle under the current ray
  function automatic logic [31:0] hit_word(input logic [287:0] tri_word);
    exact_t a[3], b[3], c[3], e1[3], e2[3], s[3], p[3], q[3], d[3];
    exact_t det, nu, nv, nt, num;
    logic [30:0] dist_val;
    for (int i = 0; i < 3; i++) begin
      a[i]  = $signed(tri_word[32*i +: 32]);
      b[i]  = $signed(tri_word[96 + 32*i +: 32]);
      c[i]  = $signed(tri_word[192 + 32*i +: 32]);
      d[i]  = ray_reg[3+i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      s[i]  = exact_t'(ray_reg[i]) - a[i];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    nu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    nv  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    nt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    // fold the sign of det into the numerators
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    if (det * 1000 <= (exact_t'(1) <<< 48)) return MISS_WORD;
    if (nu < 0 || nu > det) return MISS_WORD;
    if (nv < 0 || nu + nv > det) return MISS_WORD;
    dist_val = '0;
    if (nt > 0) begin
      num = nt <<< 16;
      if (num >= (det <<< 31)) dist_val = '1;
      else dist_val = 31'(num / det);
    end
    return {dist_val, 1'b1};
  endfunction

  function automatic logic [287:0] pack_tri(input logic [31:0] ax, ay, az, bx, by, bz,
                                            cx, cy, cz);
    return {cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx < 3'd6) ray_reg[idx] = val;
    @(posedge clk);
  endtask

  // Let the pipeline empty before touching the ray
  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    drain();
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  // Offer one word, with an occasional gap, and log its expectation
  task automatic send_tri(input logic [287:0] tri_word, input bit typed,
                          input logic [31:0] want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tri_word;
    do @(posedge clk); while (!s_tready);
    result_q.push_back(typed ? want : hit_word(tri_word));
  endtask

  // Triangle placed around a point on the ray, so that hits are common
  function automatic logic [287:0] aimed_tri(input int span);
    logic [31:0] pt[3];
    logic [31:0] v[9];
    int k;
    k = $urandom_range(0, 8);
    for (int i = 0; i < 3; i++) pt[i] = ray_reg[i] + ray_reg[3+i] * k;
    for (int j = 0; j < 9; j++)
      v[j] = pt[j % 3] + 32'($signed($urandom_range(0, 2*span)) - span);
    return {v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
  endfunction

  function automatic logic [31:0] small_coord();
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  // Result checking
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected word: hit %0b distance %0h", m_tdata[0], m_tdata[31:1]);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (m_tdata[0] !== want[0]) begin
          $error("hit: expected %0b, got %0b", want[0], m_tdata[0]);
          errors++;
        end
        if (m_tdata[31:1] !== want[31:1]) begin
          $error("distance: expected %0h, got %0h", want[31:1], m_tdata[31:1]);
          errors++;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    bit   far_set;
    errors = 0; cycles = 0; calm = 1'b0; hold_req = 1'b0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    for (int i = 0; i < 6; i++) ray_reg[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the direction is zero: every triangle is parallel
    send_tri(pack_tri(0, 0, FIVE, ONE, 0, FIVE, 0, ONE, FIVE), 1'b1, MISS_WORD);

    // directed part: ray from (0.25, 0.25, 0) along +z
    rows = '{
      '{pack_tri(0, 0, FIVE, ONE, 0, FIVE, 0, ONE, FIVE), 1, 0, {31'h0005_0000, 1'b1}},
      '{pack_tri(0, 0, -FIVE, ONE, 0, -FIVE, 0, ONE, -FIVE), 1, 0, {31'd0, 1'b1}},
      '{pack_tri(ONE, ONE, FIVE, 2*ONE, ONE, FIVE, ONE, 2*ONE, FIVE), 1, 0, MISS_WORD},
      '{pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, MISS_WORD},
      '{pack_tri(0, 0, FIVE, ONE, 0, FIVE, 2*ONE, 0, FIVE), 1, 0, MISS_WORD},
      '{pack_tri(ONE, 0, FIVE, 0, ONE, FIVE, 0, 0, FIVE), 0, 0, 0},
      '{pack_tri(QTR, 0, FIVE, QTR, ONE, FIVE, 0, 0, FIVE), 0, 0, 0},
      '{pack_tri(0, QTR, FIVE, ONE, QTR, FIVE, 0, 0, FIVE), 0, 0, 0},
      '{pack_tri(0, 0, FIVE, 2*QTR, 0, FIVE, 0, 2*QTR, FIVE), 0, 0, 0},
      '{pack_tri(32'h3F00, 32'h3F00, FIVE, 32'h3F00 + 2072, 32'h3F00, FIVE,
                 32'h3F00, 32'h3F00 + 2072, FIVE), 0, 0, 0},
      '{pack_tri(32'h3F00, 32'h3F00, FIVE, 32'h3F00 + 2073, 32'h3F00, FIVE,
                 32'h3F00, 32'h3F00 + 2073, FIVE), 0, 0, 0},
      '{{9{32'h8000_0000}}, 0, 0, 0},
      '{{9{32'h7FFF_FFFF}}, 0, 0, 0},
      '{{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, 0, 0},
      '{{9{32'hFFFF_FFFF}}, 0, 0, 0},
      '{pack_tri(32'h8000_0000, 32'h8000_0000, FIVE, 32'h7FFF_FFFF, 32'h8000_0000, FIVE,
                 32'h8000_0000, 32'h7FFF_FFFF, FIVE), 0, 0, 0},
      '{pack_tri(0, 0, 32'h7FFF_0000, ONE, 0, 32'h7FFF_0000, 0, ONE, 32'h7FFF_0000),
        1, 1, DIST_SAT},
      '{pack_tri(0, 0, 32'h7FFF_FFFF, ONE, 0, 32'h7FFF_FFFF, 0, ONE, 32'h7FFF_FFFF),
        0, 1, 0},
      '{pack_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 0, 1, 0}
    };
    set_ray(QTR, QTR, 0, 0, 0, ONE);
    // out-of-range indexes must leave the ray alone
    write_reg(REG_SPARE_6, 32'hDEAD_BEEF);
    write_reg(REG_SPARE_7, 32'h1234_5678);
    far_set = 1'b0;
    foreach (rows[r]) begin
      if (rows[r].far && !far_set) begin
        // pull the origin far back so the distance overflows
        drain();
        write_reg(REG_ORG_Z, 32'h8000_0000);
        far_set = 1'b1;
      end
      send_tri(rows[r].tri_word, rows[r].typed, rows[r].want);
    end

    // random part: one ray per phase, extremes among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_ray(small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord());
        1: set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        3: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: set_ray(small_coord(), small_coord(), small_coord(), 0, 0, 0);
        default: set_ray(small_coord(), small_coord(), small_coord(),
                         small_coord(), small_coord(), small_coord());
      endcase
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 147; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        case ($urandom_range(0, 7))
          0, 1: send_tri({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom}, 1'b0, 0);
          2:    send_tri(aimed_tri(32'h7FFF_FFFF), 1'b0, 0);
          3, 4: send_tri(aimed_tri(32'h0000_4000), 1'b0, 0);
          default: send_tri(aimed_tri(32'h0004_0000), 1'b0, 0);
        endcase
      end
    end

    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
